// File: rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and codes of the link retry supervisor: event, result and
// configuration records, action, link state, command and error codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // Event kinds
  localparam logic [1:0] ACT_TICK        = 2'd0;
  localparam logic [1:0] ACT_SETUP       = 2'd1;
  localparam logic [1:0] ACT_CREDENTIALS = 2'd2;
  localparam logic [1:0] ACT_FACTORY     = 2'd3;

  // Reported link states
  localparam logic [2:0] LINK_CONNECTING   = 3'd0;
  localparam logic [2:0] LINK_CONNECTED    = 3'd1;
  localparam logic [2:0] LINK_ADVANCED_UP  = 3'd2;
  localparam logic [2:0] LINK_SSID_MISSING = 3'd3;
  localparam logic [2:0] LINK_BAD_CREDS    = 3'd4;
  localparam logic [2:0] LINK_ADV_FAILED   = 3'd5;

  // Modes
  localparam logic MODE_WAITING      = 1'b0;
  localparam logic MODE_BOOTSTRAPPED = 1'b1;

  // Connect commands
  localparam logic [1:0] CMD_NONE         = 2'd0;
  localparam logic [1:0] CMD_PROVISIONING = 2'd1;
  localparam logic [1:0] CMD_DESTINATION  = 2'd2;
  localparam logic [1:0] CMD_ADVANCED     = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK          = 2'd0;
  localparam logic [1:0] ERR_NOT_FOUND   = 2'd1;
  localparam logic [1:0] ERR_CREDENTIALS = 2'd2;
  localparam logic [1:0] ERR_ADVANCED    = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIES_PROV  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIES_DEST  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEED_ADVANCED = 8'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the registers
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0]  RETRIES_RESET = 8'd3;

  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] attempt_timeout_ms;
    logic [7:0]  retries_provisioning;
    logic [7:0]  retries_destination;
    logic        need_advanced;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [2:0]  link_state;
    logic        credentials_present;
  } event_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] command;
    logic [1:0] error_code;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/lrs_cfg.sv
// ----------------------------------------------------------------------------
// lrs_cfg
// Configuration register file: timeout, retry limits and advanced flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrs_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [lrs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [lrs_pkg::CFG_DATA_W-1:0]  wr_data,
  output lrs_pkg::cfg_t                        cfg
);

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attempt_timeout_ms   <= lrs_pkg::TIMEOUT_RESET;
      cfg.retries_provisioning <= lrs_pkg::RETRIES_RESET;
      cfg.retries_destination  <= lrs_pkg::RETRIES_RESET;
      cfg.need_advanced        <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        lrs_pkg::REG_TIMEOUT:       cfg.attempt_timeout_ms   <= wr_data[15:0];
        lrs_pkg::REG_RETRIES_PROV:  cfg.retries_provisioning <= wr_data[7:0];
        lrs_pkg::REG_RETRIES_DEST:  cfg.retries_destination  <= wr_data[7:0];
        lrs_pkg::REG_NEED_ADVANCED: cfg.need_advanced        <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lrs_core.sv
// ----------------------------------------------------------------------------
// lrs_core
// Supervisor state and its combinational update: mode, credentials flag,
// attempt counter, three deadlines and last error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrs_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire lrs_pkg::event_t ev,
  input  wire lrs_pkg::cfg_t   cfg,
  output lrs_pkg::result_t     res
);

  logic        mode, mode_next;
  logic        has_cred, has_cred_next;
  logic [7:0]  count, count_next;
  logic [31:0] prov_dl, prov_dl_next;
  logic [31:0] dest_dl, dest_dl_next;
  logic [31:0] adv_dl, adv_dl_next;
  logic [1:0]  last_err, last_err_next;
  logic [1:0]  cmd;

  logic [32:0] dl_sum;
  logic [31:0] deadline;
  logic [7:0]  count_bumped;
  logic        to_waiting, to_boot;
  logic [1:0]  wait_code;

  // Saturating deadline and counter increment
  assign dl_sum       = {1'b0, ev.now_ms} + {17'd0, cfg.attempt_timeout_ms};
  assign deadline     = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
  assign count_bumped = (count == lrs_pkg::COUNT_MAX) ? count : count + 8'd1;

  // Event decode and state update
  always_comb begin
    mode_next     = mode;
    has_cred_next = has_cred;
    count_next    = count;
    prov_dl_next  = prov_dl;
    dest_dl_next  = dest_dl;
    adv_dl_next   = adv_dl;
    last_err_next = last_err;
    cmd           = lrs_pkg::CMD_NONE;
    to_waiting    = 1'b0;
    to_boot       = 1'b0;
    wait_code     = lrs_pkg::ERR_OK;

    case (ev.action)
      lrs_pkg::ACT_SETUP: begin
        has_cred_next = ev.credentials_present;
        to_boot       = ev.credentials_present;
        to_waiting    = !ev.credentials_present;
      end
      lrs_pkg::ACT_CREDENTIALS: begin
        has_cred_next = 1'b1;
        to_boot       = 1'b1;
      end
      lrs_pkg::ACT_FACTORY: begin
        has_cred_next = 1'b0;
        to_waiting    = 1'b1;
      end
      default: begin
        if (mode == lrs_pkg::MODE_WAITING) begin
          // Retry provisioning once the deadline has been reached
          if (ev.link_state != lrs_pkg::LINK_CONNECTED && prov_dl <= ev.now_ms) begin
            prov_dl_next = deadline;
            cmd          = lrs_pkg::CMD_PROVISIONING;
            if (has_cred) begin
              count_next = count_bumped;
              to_boot    = (count_bumped >= cfg.retries_provisioning);
            end
          end
        end else begin
          case (ev.link_state)
            lrs_pkg::LINK_SSID_MISSING: begin
              to_waiting = 1'b1;
              wait_code  = lrs_pkg::ERR_NOT_FOUND;
            end
            lrs_pkg::LINK_BAD_CREDS: begin
              to_waiting = 1'b1;
              wait_code  = lrs_pkg::ERR_CREDENTIALS;
            end
            lrs_pkg::LINK_ADV_FAILED: begin
              to_waiting = 1'b1;
              wait_code  = lrs_pkg::ERR_ADVANCED;
            end
            lrs_pkg::LINK_ADVANCED_UP: begin
              last_err_next = lrs_pkg::ERR_OK;
            end
            lrs_pkg::LINK_CONNECTED: begin
              if (!cfg.need_advanced) begin
                last_err_next = lrs_pkg::ERR_OK;
              end else if (count > cfg.retries_destination) begin
                to_waiting = 1'b1;
                wait_code  = lrs_pkg::ERR_ADVANCED;
              end else if (ev.now_ms > adv_dl) begin
                count_next  = count_bumped;
                adv_dl_next = deadline;
                cmd         = lrs_pkg::CMD_ADVANCED;
              end
            end
            default: begin
              // Still connecting: retry the destination network
              if (ev.now_ms > dest_dl) begin
                dest_dl_next = deadline;
                count_next   = count_bumped;
                cmd          = lrs_pkg::CMD_DESTINATION;
                if (count_bumped >= cfg.retries_destination) begin
                  to_waiting = 1'b1;
                  wait_code  = lrs_pkg::ERR_NOT_FOUND;
                end
              end
            end
          endcase
        end
      end
    endcase

    // Mode entries override the per-state updates
    if (to_waiting) begin
      count_next    = 8'd0;
      dest_dl_next  = 32'd0;
      adv_dl_next   = 32'd0;
      last_err_next = wait_code;
      mode_next     = lrs_pkg::MODE_WAITING;
      prov_dl_next  = deadline;
      cmd           = lrs_pkg::CMD_PROVISIONING;
    end else if (to_boot) begin
      count_next    = 8'd0;
      prov_dl_next  = 32'd0;
      adv_dl_next   = 32'd0;
      last_err_next = lrs_pkg::ERR_OK;
      mode_next     = lrs_pkg::MODE_BOOTSTRAPPED;
      dest_dl_next  = deadline;
      cmd           = lrs_pkg::CMD_DESTINATION;
    end
  end

  assign res.mode       = mode_next;
  assign res.command    = cmd;
  assign res.error_code = last_err_next;

  // Advance state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= lrs_pkg::MODE_WAITING;
      has_cred <= 1'b0;
      count    <= 8'd0;
      prov_dl  <= 32'd0;
      dest_dl  <= 32'd0;
      adv_dl   <= 32'd0;
      last_err <= lrs_pkg::ERR_OK;
    end else if (step) begin
      mode     <= mode_next;
      has_cred <= has_cred_next;
      count    <= count_next;
      prov_dl  <= prov_dl_next;
      dest_dl  <= dest_dl_next;
      adv_dl   <= adv_dl_next;
      last_err <= last_err_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/link_retry_supervisor.sv
// ----------------------------------------------------------------------------
// link_retry_supervisor
// Two-mode link supervisor: provisioning retries, destination and advanced
// connection retries with saturating deadlines, one result item per event.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tuser action, s_tdata event fields
//   m_*      out        m_tvalid/m_tready  m_tdata mode, command, error code
//   cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// One item per cycle sustained while the result side takes them; each item
// passes through the input register and then the result register.
// The whole update is one pass of compares, a 33-bit add and the counter.
// A stalled output holds its result; one further item waits in the input
// register, after which s_tready drops. cfg_ready is always high.
// Synchronous reset restores the register defaults, the supervisor state and valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module link_retry_supervisor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Event stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [39:0]                     s_tdata,  // now_ms[31:0], link_state[34:32],
                                                         // credentials_present[35], zeros
  input  wire logic [1:0]                      s_tuser,  // action[1:0]
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [7:0]                           m_tdata,  // mode[0], command[2:1],
                                                         // error_code[4:3], zeros
  // Configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lrs_pkg::cfg_t    cfg;
  lrs_pkg::event_t  ev;
  lrs_pkg::result_t res;
  lrs_pkg::result_t out_res;
  logic             in_valid;
  logic             advance;

  assign cfg_ready = 1'b1;

  lrs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Process the held item when the result slot is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ev.action              <= s_tuser;
      ev.now_ms              <= s_tdata[31:0];
      ev.link_state          <= s_tdata[34:32];
      ev.credentials_present <= s_tdata[35];
    end
  end

  lrs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ev   (ev),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'd0, out_res.error_code, out_res.command, out_res.mode};

  // A held item is never dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input item lost while stalled");

  // Provisioning commands only come from waiting mode
  a_prov_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.command == lrs_pkg::CMD_PROVISIONING)
      |-> out_res.mode == lrs_pkg::MODE_WAITING)
    else $error("provisioning command outside waiting mode");

  // Destination and advanced commands only come from bootstrapped mode
  a_dest_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.command == lrs_pkg::CMD_DESTINATION ||
                  out_res.command == lrs_pkg::CMD_ADVANCED))
      |-> out_res.mode == lrs_pkg::MODE_BOOTSTRAPPED)
    else $error("destination command outside bootstrapped mode");

  // Entering bootstrapped mode clears the error, so an error implies waiting
  a_err_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.error_code != lrs_pkg::ERR_OK)
      |-> out_res.mode == lrs_pkg::MODE_WAITING)
    else $error("error reported in bootstrapped mode");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the link retry supervisor. A directed script covers
// resets, setup, stored credentials, every link state and deadline saturation.
// Then random event sequences run under several register settings, the
// extremes among them. Each accepted event is run through a local model of
// the supervisor and the result stream is compared field by field. Both
// stream sides idle at random, and once the result side holds off for long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lrs_pkg::*;

  localparam int STAGES       = 8;
  localparam int STAGE_EVENTS = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;

  // Directed script row: the wanted result is only used when checked is set
  typedef struct packed {
    event_t  ev;
    logic    checked;
    result_t want;
  } script_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = ACT_TICK;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model state of the supervisor and its register copy
  cfg_t        knobs;
  logic        mode_now   = MODE_WAITING;
  logic        creds_held = 1'b0;
  logic [7:0]  tries      = '0;
  logic [31:0] prov_due   = '0;
  logic [31:0] dest_due   = '0;
  logic [31:0] adv_due    = '0;
  logic [1:0]  last_err   = ERR_OK;

  // Stimulus bookkeeping
  script_row_t script [$];
  result_t     outcomes [$];
  logic [31:0] clock_ms = '0;
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int          events_sent     = 0;
  int          results_checked = 0;
  int          cfg_writes      = 0;
  int          faults          = 0;
  int          cycles          = 0;
  int          cmd_hits [4]    = '{0, 0, 0, 0};
  int          err_hits [4]    = '{0, 0, 0, 0};

  link_retry_supervisor uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Supervisor model
  // --------------------------------------------------------------------------

  // Deadline: now plus timeout, clamped at the top of the 32-bit range
  function automatic logic [31:0] due_after(input logic [31:0] now);
    logic [32:0] sum;
    sum = {1'b0, now} + {17'd0, knobs.attempt_timeout_ms};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void count_attempt();
    if (tries != COUNT_MAX) tries++;
  endfunction

  function automatic logic [1:0] fall_back(input logic [1:0] code, input logic [31:0] now);
    tries    = '0;
    dest_due = '0;
    adv_due  = '0;
    last_err = code;
    mode_now = MODE_WAITING;
    prov_due = due_after(now);
    return CMD_PROVISIONING;
  endfunction

  function automatic logic [1:0] join_destination(input logic [31:0] now);
    tries    = '0;
    prov_due = '0;
    adv_due  = '0;
    last_err = ERR_OK;
    mode_now = MODE_BOOTSTRAPPED;
    dest_due = due_after(now);
    return CMD_DESTINATION;
  endfunction

  function automatic logic [1:0] tick_command(input logic [31:0] now, input logic [2:0] link);
    logic [1:0] cmd;
    cmd = CMD_NONE;
    if (mode_now == MODE_WAITING) begin
      // Retry provisioning; with credentials, give up on it after enough tries
      if (link != LINK_CONNECTED && prov_due <= now) begin
        prov_due = due_after(now);
        cmd = CMD_PROVISIONING;
        if (creds_held) begin
          count_attempt();
          if (tries >= knobs.retries_provisioning) cmd = join_destination(now);
        end
      end
    end else begin
      case (link)
        LINK_SSID_MISSING: cmd = fall_back(ERR_NOT_FOUND, now);
        LINK_BAD_CREDS:    cmd = fall_back(ERR_CREDENTIALS, now);
        LINK_ADV_FAILED:   cmd = fall_back(ERR_ADVANCED, now);
        LINK_ADVANCED_UP:  last_err = ERR_OK;
        LINK_CONNECTED: begin
          if (!knobs.need_advanced) begin
            last_err = ERR_OK;
          end else if (tries > knobs.retries_destination) begin
            cmd = fall_back(ERR_ADVANCED, now);
          end else if (now > adv_due) begin
            count_attempt();
            adv_due = due_after(now);
            cmd = CMD_ADVANCED;
          end
        end
        default: begin
          // Still connecting: retry the destination until the budget runs out
          if (now > dest_due) begin
            dest_due = due_after(now);
            count_attempt();
            if (tries >= knobs.retries_destination) cmd = fall_back(ERR_NOT_FOUND, now);
            else cmd = CMD_DESTINATION;
          end
        end
      endcase
    end
    return cmd;
  endfunction

  function automatic result_t predict_event(input event_t ev);
    result_t    r;
    logic [1:0] cmd;
    case (ev.action)
      ACT_SETUP: begin
        creds_held = ev.credentials_present;
        if (ev.credentials_present) cmd = join_destination(ev.now_ms);
        else cmd = fall_back(ERR_OK, ev.now_ms);
      end
      ACT_CREDENTIALS: begin
        creds_held = 1'b1;
        cmd = join_destination(ev.now_ms);
      end
      ACT_FACTORY: begin
        creds_held = 1'b0;
        cmd = fall_back(ERR_OK, ev.now_ms);
      end
      default: cmd = tick_command(ev.now_ms, ev.link_state);
    endcase
    r.mode       = mode_now;
    r.command    = cmd;
    r.error_code = last_err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic void row(input logic [1:0] act, input logic [31:0] now,
                              input logic [2:0] link, input logic creds, input logic checked,
                              input logic mode, input logic [1:0] cmd, input logic [1:0] err);
    script_row_t r;
    r.ev.action              = act;
    r.ev.now_ms              = now;
    r.ev.link_state          = link;
    r.ev.credentials_present = creds;
    r.checked                = checked;
    r.want.mode              = mode;
    r.want.command           = cmd;
    r.want.error_code        = err;
    script.push_back(r);
  endfunction

  // Mostly ticks on a clock that moves forward around the timeout, with link
  // states that suit the current mode; a few events are pure noise
  function automatic event_t roll_event();
    event_t      ev;
    int unsigned pick;
    logic [32:0] later;
    ev.credentials_present = 1'b0;
    if ($urandom_range(99) < 5) begin
      ev.action              = 2'($urandom_range(3));
      ev.now_ms              = $urandom;
      ev.link_state          = 3'($urandom_range(7));
      ev.credentials_present = 1'($urandom_range(1));
      return ev;
    end

    pick = $urandom_range(99);
    if (pick < 55) begin
      later = {1'b0, clock_ms} + 33'($urandom_range(2 * knobs.attempt_timeout_ms + 2));
      clock_ms = later[32] ? 32'hFFFF_FFFF : later[31:0];
    end else if (pick < 88 && pick >= 75) begin
      later = {1'b0, clock_ms} + 33'($urandom_range(3, 1));
      clock_ms = later[32] ? 32'hFFFF_FFFF : later[31:0];
    end else if (pick >= 88 && pick < 94) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(2 * knobs.attempt_timeout_ms);
    end else if (pick >= 94) begin
      clock_ms = $urandom;
    end
    ev.now_ms = clock_ms;

    pick = $urandom_range(99);
    if (pick < 3) begin
      ev.action              = ACT_SETUP;
      ev.credentials_present = 1'($urandom_range(1));
    end else if (pick < 6) begin
      ev.action = ACT_CREDENTIALS;
    end else if (pick < 8) begin
      ev.action = ACT_FACTORY;
    end else begin
      ev.action = ACT_TICK;
    end

    pick = $urandom_range(99);
    if (mode_now == MODE_WAITING) begin
      if (pick < 70)      ev.link_state = LINK_CONNECTING;
      else if (pick < 85) ev.link_state = LINK_CONNECTED;
      else                ev.link_state = 3'($urandom_range(7, 2));
    end else begin
      if (pick < 35)      ev.link_state = LINK_CONNECTING;
      else if (pick < 63) ev.link_state = LINK_CONNECTED;
      else if (pick < 77) ev.link_state = LINK_ADVANCED_UP;
      else if (pick < 80) ev.link_state = LINK_SSID_MISSING;
      else if (pick < 83) ev.link_state = LINK_BAD_CREDS;
      else if (pick < 86) ev.link_state = LINK_ADV_FAILED;
      else                ev.link_state = 3'($urandom_range(7, 6));
    end
    return ev;
  endfunction

  // Offer one event, hold it until taken, then log what it should produce
  task automatic offer_event(input event_t ev, input logic checked, input result_t want);
    result_t guess;
    while (!calm && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.action;
    s_tdata  <= {4'b0000, ev.credentials_present, ev.link_state, ev.now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    guess = predict_event(ev);
    outcomes.push_back(checked ? want : guess);
    events_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIMEOUT:       knobs.attempt_timeout_ms   = val;
      REG_RETRIES_PROV:  knobs.retries_provisioning = val[7:0];
      REG_RETRIES_DEST:  knobs.retries_destination  = val[7:0];
      REG_NEED_ADVANCED: knobs.need_advanced        = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Drain every outstanding result, then let the pipeline idle before going on
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run
    cfg_t plan;
    int   stage;
    knobs = '{TIMEOUT_RESET, RETRIES_RESET, RETRIES_RESET, 1'b0};

    // Directed script under reset settings (timeout 5000, three retries each)
    row(ACT_TICK,        32'd0,          LINK_CONNECTING,   1'b0, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_OK);
    row(ACT_TICK,        32'd0,          LINK_CONNECTED,    1'b0, 1'b1,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'd4999,       LINK_CONNECTING,   1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_SETUP,       32'd5000,       LINK_CONNECTING,   1'b0, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_OK);
    row(ACT_SETUP,       32'hFFFF_FFFF,  LINK_CONNECTING,   1'b1, 1'b1,
        MODE_BOOTSTRAPPED, CMD_DESTINATION,  ERR_OK);
    // Saturated deadline equals now, so no retry yet
    row(ACT_TICK,        32'hFFFF_FFFF,  LINK_CONNECTING,   1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'd100,        LINK_SSID_MISSING, 1'b0, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_NOT_FOUND);
    // Stored credentials ignore the link state
    row(ACT_CREDENTIALS, 32'd200,        LINK_ADV_FAILED,   1'b0, 1'b1,
        MODE_BOOTSTRAPPED, CMD_DESTINATION,  ERR_OK);
    row(ACT_TICK,        32'd300,        LINK_BAD_CREDS,    1'b0, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_CREDENTIALS);
    row(ACT_CREDENTIALS, 32'd400,        LINK_CONNECTING,   1'b0, 1'b1,
        MODE_BOOTSTRAPPED, CMD_DESTINATION,  ERR_OK);
    row(ACT_TICK,        32'd500,        LINK_ADV_FAILED,   1'b0, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_ADVANCED);
    row(ACT_TICK,        32'd600,        LINK_ADVANCED_UP,  1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_FACTORY,     32'd700,        LINK_CONNECTED,    1'b1, 1'b1,
        MODE_WAITING,      CMD_PROVISIONING, ERR_OK);
    row(ACT_CREDENTIALS, 32'd0,          LINK_CONNECTING,   1'b0, 1'b1,
        MODE_BOOTSTRAPPED, CMD_DESTINATION,  ERR_OK);
    // Link states six and seven behave as still connecting; run out the budget
    row(ACT_TICK,        32'd5001,       3'd6,              1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'd10002,      3'd7,              1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'd15003,      LINK_CONNECTING,   1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'd15004,      LINK_ADVANCED_UP,  1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    // Credentials survive the fall-back: provisioning retries count again
    row(ACT_TICK,        32'd20003,      LINK_CONNECTING,   1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'hFFFF_FFFF,  LINK_BAD_CREDS,    1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'hFFFF_FFFF,  3'd7,              1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'hFFFF_FFFF,  LINK_ADVANCED_UP,  1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_TICK,        32'hFFFF_FFFF,  LINK_CONNECTED,    1'b0, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);
    row(ACT_SETUP,       32'hAAAA_5555,  3'd7,              1'b1, 1'b0,
        MODE_WAITING,      CMD_NONE,         ERR_OK);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer_event(script[i].ev, script[i].checked, script[i].want);

    // Random sequences, one register setting per stage
    for (stage = 0; stage < STAGES; stage++) begin
      settle();
      case (stage)
        0:       plan = '{16'd0,     8'd0,   8'd0,   1'b0};
        1:       plan = '{16'hFFFF,  8'd255, 8'd255, 1'b1};
        2:       plan = '{16'd1000,  8'd3,   8'd3,   1'b1};
        3:       plan = '{16'd200,   8'd1,   8'd2,   1'b0};
        4:       plan = '{16'($urandom), 8'($urandom_range(8)), 8'($urandom_range(8)), 1'b1};
        5:       plan = '{16'd10,    8'd5,   8'd4,   1'b1};
        6:       plan = '{16'hFFFF,  8'd2,   8'd6,   1'b0};
        default: plan = '{16'd0,     8'd255, 8'd0,   1'b1};
      endcase
      write_reg(REG_TIMEOUT,       plan.attempt_timeout_ms);
      write_reg(REG_RETRIES_PROV,  {8'd0, plan.retries_provisioning});
      write_reg(REG_RETRIES_DEST,  {8'd0, plan.retries_destination});
      write_reg(REG_NEED_ADVANCED, {15'd0, plan.need_advanced});
      cfg_valid <= 1'b0;
      calm = (stage == 2);
      if (stage == 4) hold_req = 1'b1;
      repeat (STAGE_EVENTS) offer_event(roll_event(), 1'b0, '0);
    end

    // Drain and report
    s_tvalid <= 1'b0;
    while (outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d events (%0d directed) across %0d register writes; %0d results checked.",
             events_sent, script.size(), cfg_writes, results_checked);
    $display("Commands none/prov/dest/adv: %0d/%0d/%0d/%0d; errors ok/nf/cred/adv: %0d/%0d/%0d/%0d",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3],
             err_hits[0], err_hits[1], err_hits[2], err_hits[3]);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", faults);
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : drain
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 25) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void note_fault(input string what);
    faults++;
    if (faults <= 10) $display("MISMATCH at %0t, result %0d: %s", $time, results_checked, what);
  endfunction

  // Compare each taken result with the oldest outstanding prediction
  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.mode       = m_tdata[0];
      got.command    = m_tdata[2:1];
      got.error_code = m_tdata[4:3];
      if (outcomes.size() == 0) begin
        note_fault($sformatf("unexpected result %b", m_tdata));
      end else begin
        want = outcomes.pop_front();
        if (got.mode !== want.mode)
          note_fault($sformatf("mode expected %0d got %0d", want.mode, got.mode));
        if (got.command !== want.command)
          note_fault($sformatf("command expected %0d got %0d", want.command, got.command));
        if (got.error_code !== want.error_code)
          note_fault($sformatf("error_code expected %0d got %0d",
                               want.error_code, got.error_code));
        cmd_hits[want.command]++;
        err_hits[want.error_code]++;
      end
      results_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, outcomes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/lrs_pkg.sv
rtl/lrs_cfg.sv
rtl/lrs_core.sv
rtl/link_retry_supervisor.sv
tb/testbench.sv
